>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DUMP_FWD   = 3'd4,
      ACT_DUMP_BACK  = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       dump_start;
      logic       dump_rev;
      logic       issue_read;
      logic       load_single;
      logic       load_dump;
      status_type single_status;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic issue_done;
      logic pend_last;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and holds
// while no read is requested.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/deq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Front pointer, occupancy count, entry store, dump counter and the
// result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  deq_pkg::cmd_type                  cmd,
   output deq_pkg::stat_type                 stat,
   input  logic signed [deq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_data,
   output logic                              rsp_last
);
   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [IDX_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [CNT_W-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                      dump_rev_ff, dump_rev_in;
   logic                      pend_last_ff, pend_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]  front_dec;
   logic [IDX_W-1:0]  front_inc;
   logic [IDX_W-1:0]  back_next;
   logic [CNT_W-1:0]  dump_off;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic              wr_en;
   logic [DATA_W-1:0] rd_data;

   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign front_inc = wrap_add(front_ff, CNT_W'(1));
   assign back_next = wrap_add(front_ff, occ_ff);
   assign dump_off  = dump_rev_ff ? occ_ff - CNT_W'(1) - issue_cnt_ff : issue_cnt_ff;
   assign rd_addr   = wrap_add(front_ff, dump_off);
   assign wr_en     = cmd.push_front | cmd.push_back;
   assign wr_addr   = cmd.push_front ? front_dec : back_next;

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      front_in     = front_ff;
      occ_in       = occ_ff;
      issue_cnt_in = issue_cnt_ff;
      dump_rev_in  = dump_rev_ff;
      pend_last_in = pend_last_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
      end else if (cmd.pop_front) begin
         front_in = front_inc;
      end
      if (cmd.push_front || cmd.push_back) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (cmd.pop_front || cmd.pop_back) begin
         occ_in = occ_ff - CNT_W'(1);
      end
      if (cmd.dump_start) begin
         issue_cnt_in = '0;
         dump_rev_in  = cmd.dump_rev;
      end else if (cmd.issue_read) begin
         issue_cnt_in = issue_cnt_ff + CNT_W'(1);
         pend_last_in = (issue_cnt_ff + CNT_W'(1)) == occ_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_single) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.single_status;
         rsp_data_in   = '0;
         rsp_last_in   = 1'b1;
      end else if (cmd.load_dump) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_data_in   = $signed(rd_data);
         rsp_last_in   = pend_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         issue_cnt_ff <= '0;
         dump_rev_ff  <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         issue_cnt_ff <= issue_cnt_in;
         dump_rev_ff  <= dump_rev_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.empty      = occ_ff == '0;
   assign stat.full       = occ_ff == DEPTH_C;
   assign stat.issue_done = issue_cnt_ff == occ_ff;
   assign stat.pend_last  = pend_last_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

>>> rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes each accepted word and sequences the reads of a dump.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [deq_pkg::ACTION_W-1:0]  req_action,
   input  deq_pkg::stat_type             stat,
   output deq_pkg::cmd_type              cmd
);
   import deq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               unique case (action_type'(req_action))
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     cmd.load_single = 1'b1;
                     if (stat.full) begin
                        cmd.single_status = ST_FULL;
                     end else begin
                        cmd.single_status = ST_OK;
                        cmd.push_front = action_type'(req_action) == ACT_PUSH_FRONT;
                        cmd.push_back  = action_type'(req_action) == ACT_PUSH_BACK;
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     cmd.load_single = 1'b1;
                     if (stat.empty) begin
                        cmd.single_status = ST_EMPTY;
                     end else begin
                        cmd.single_status = ST_OK;
                        cmd.pop_front = action_type'(req_action) == ACT_POP_FRONT;
                        cmd.pop_back  = action_type'(req_action) == ACT_POP_BACK;
                     end
                  end
                  ACT_DUMP_FWD, ACT_DUMP_BACK: begin
                     if (stat.empty) begin
                        cmd.load_single   = 1'b1;
                        cmd.single_status = ST_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                        cmd.dump_rev   = action_type'(req_action) == ACT_DUMP_BACK;
                        pend_in        = 1'b0;
                        state_in       = S_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            cmd.load_dump  = pend_ff && stat.out_free;
            cmd.issue_read = !stat.issue_done && (!pend_ff || stat.out_free);
            pend_in        = cmd.issue_read || (pend_ff && !cmd.load_dump);
            if (cmd.load_dump && stat.pend_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Push and pop: the result is registered as the word is accepted.
// Dump of n entries: the dump state issues the reads of the entry store, whose
// registered read port feeds the result register; from then on one result per
// cycle while the receiver takes them. A new word is accepted once the result
// register is free or being taken and no dump is running.
// Reset clears the pointers, the count and the controller; store contents stay.
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed words in a circular store with push, pop and dump.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [deq_pkg::ACTION_W-1:0]      req_action,
   input  logic signed [deq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0] rsp_data,
   output logic                              rsp_last
);
   import deq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

endmodule

>>> rtl/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [deq_pkg::ACTION_W-1:0]      req_action,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [deq_pkg::DATA_W-1:0] rsp_data,
   input logic                              rsp_last
);
   import deq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
                                  && $stable(rsp_status) && $stable(rsp_last))
      else $error("Stalled result word changed.");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Request taken while the result register is blocked.");

   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_W'(ST_OK) |-> rsp_last && rsp_data == '0)
      else $error("Error result is not a single zero word.");

   a_push_pop_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action <= ACTION_W'(ACT_POP_BACK)
      |=> rsp_valid && rsp_last && rsp_data == '0)
      else $error("Push or pop did not answer with one word.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

>>> bench/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and dump words into the block and checks every result
// against a predicted copy of the queue. A directed pass covers the empty and
// full cases first. Random bursts, each chosen at random to fill, drain or mix,
// then run across phases with no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 40;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
      int                       phase;
   } deq_word_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } deq_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACTION_W-1:0]       req_action = '0;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [DATA_W-1:0]  rsp_data;
   logic                      rsp_last;

   deq_word_type   pending_words[$];
   deq_result_type expected_results[$];

   logic signed [DATA_W-1:0] queue_store[DEPTH];
   int          queue_head = 0;
   int          queue_count = 0;
   int          current_phase = 0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          sender_idle[4]    = '{0, 73, 0, 16};
   int          receiver_stall[4] = '{0, 0, 73, 16};

   double_ended_queue #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void add_result(status_type status, logic signed [DATA_W-1:0] data,
                                      logic last);
      deq_result_type r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_results(logic [ACTION_W-1:0] action,
                                           logic signed [DATA_W-1:0] value);
      int offset;
      case (action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (queue_count == DEPTH) begin
               add_result(ST_FULL, '0, 1'b1);
            end else begin
               if (action == ACT_PUSH_FRONT) begin
                  queue_head = (queue_head + DEPTH - 1) % DEPTH;
                  queue_store[queue_head] = value;
               end else begin
                  queue_store[(queue_head + queue_count) % DEPTH] = value;
               end
               queue_count++;
               add_result(ST_OK, '0, 1'b1);
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (queue_count == 0) begin
               add_result(ST_EMPTY, '0, 1'b1);
            end else begin
               if (action == ACT_POP_FRONT) begin
                  queue_head = (queue_head + 1) % DEPTH;
               end
               queue_count--;
               add_result(ST_OK, '0, 1'b1);
            end
         end
         ACT_DUMP_FWD, ACT_DUMP_BACK: begin
            if (queue_count == 0) begin
               add_result(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < queue_count; i++) begin
                  offset = (action == ACT_DUMP_FWD) ? i : queue_count - 1 - i;
                  add_result(ST_OK, queue_store[(queue_head + offset) % DEPTH],
                             i == queue_count - 1);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Driver: a word leaves the pending list only when the channel slot is free.
   always @(posedge clock) begin : drive_words
      deq_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_results(req_action, req_value);
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 &&
                $urandom_range(99) >= sender_idle[pending_words[0].phase]) begin
               next_word = pending_words.pop_front();
               req_valid     <= 1'b1;
               req_action    <= next_word.action;
               req_value     <= next_word.value;
               current_phase <= next_word.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      deq_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result: status %0d data %0d last %0d",
                           rsp_status, rsp_data, rsp_last);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status || rsp_data !== want.data ||
                   rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"mismatch: expected status %0d data %0d last %0d, ",
                               "got status %0d data %0d last %0d"},
                              want.status, want.data, want.last,
                              rsp_status, rsp_data, rsp_last);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall[current_phase]);
      end
   end

   task automatic add_word(logic [ACTION_W-1:0] action, logic signed [DATA_W-1:0] value,
                           int phase);
      deq_word_type w;
      w.action = action;
      w.value  = value;
      w.phase  = phase;
      pending_words.push_back(w);
   endtask

   task automatic add_random_phase(int phase, int count);
      int made;
      int mode;
      int burst;
      int pick;
      logic [ACTION_W-1:0] action;
      logic signed [DATA_W-1:0] value;
      made = 0;
      while (made < count) begin
         mode  = $urandom_range(2);
         burst = $urandom_range(4, 24);
         for (int k = 0; k < burst && made < count; k++) begin
            pick = $urandom_range(99);
            if (mode == 0) begin
               action = (pick < 70) ? ($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT) :
                        (pick < 85) ? ($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT) :
                        ($urandom_range(1) ? ACT_DUMP_BACK : ACT_DUMP_FWD);
            end else if (mode == 1) begin
               action = (pick < 65) ? ($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT) :
                        (pick < 80) ? ($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT) :
                        ($urandom_range(1) ? ACT_DUMP_BACK : ACT_DUMP_FWD);
            end else begin
               action = ACTION_W'($urandom_range(5));
            end
            pick = $urandom_range(15);
            value = (pick == 0) ? VALUE_MIN : (pick == 1) ? VALUE_MAX : $urandom;
            add_word(action, value, phase);
            made++;
            if ($urandom_range(99) < 3) begin
               add_word($urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO, $urandom, phase);
            end
         end
      end
   endtask

   initial begin
      // Empty queue, unused codes, and popping the sole entry.
      add_word(ACT_POP_FRONT, '0, 0);
      add_word(ACT_POP_BACK, '0, 0);
      add_word(ACT_DUMP_FWD, '0, 0);
      add_word(ACT_DUMP_BACK, '0, 0);
      add_word(ACT_SPARE_LO, VALUE_MAX, 0);
      add_word(ACT_SPARE_HI, VALUE_MIN, 0);
      add_word(ACT_PUSH_FRONT, VALUE_MIN, 0);
      add_word(ACT_POP_BACK, '0, 0);
      // Fill from both ends, then push into the full queue and dump it.
      add_word(ACT_PUSH_FRONT, VALUE_MIN, 0);
      add_word(ACT_PUSH_BACK, VALUE_MAX, 0);
      add_word(ACT_PUSH_FRONT, '0, 0);
      add_word(ACT_PUSH_BACK, -1, 0);
      for (int i = 4; i < DEPTH; i++) begin
         add_word((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom, 0);
      end
      add_word(ACT_PUSH_FRONT, VALUE_MAX, 0);
      add_word(ACT_PUSH_BACK, VALUE_MIN, 0);
      add_word(ACT_DUMP_FWD, '0, 0);
      add_word(ACT_DUMP_BACK, '0, 0);
      for (int p = 0; p < 4; p++) begin
         add_random_phase(p, 125);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0d expected results never arrived", expected_results.size());
         end
      end
      if (mismatch_count == 0) begin
         $display("double_ended_queue test passed");
      end else begin
         $display("double_ended_queue test failed");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("double_ended_queue test failed");
      $finish;
   end

endmodule
